### hdl/gbse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbse_pkg
// Shared types, constants and kernel tables of the blur and edge block.
// ----------------------------------------------------------------------------
package gbse_pkg;

	// Frame limits
	localparam int MAX_WIDTH_DEF = 1024;
	localparam int MAX_HEIGHT    = 4096;
	localparam int WREG_W        = 11;
	localparam int HREG_W        = 13;
	localparam int IN_ROWS       = 6;
	localparam int BLUR_ROWS     = 4;

	// Divide by 159: reciprocal scaled by 2^22, then one correction step
	localparam int          DIV_BY    = 159;
	localparam logic [14:0] DIV_RECIP = 15'd26379;
	localparam int          DIV_SHIFT = 22;

	// Square root operand width
	localparam int SQ_W = 22;

	// Configuration register indexes
	typedef enum logic {
		CFG_WIDTH  = 1'b0,
		CFG_HEIGHT = 1'b1
	} cfg_idx_t;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHK,
		ST_BRD,
		ST_BLAST,
		ST_DIV1,
		ST_DIV2,
		ST_BWR,
		ST_SRD,
		ST_SLAST,
		ST_SQ1,
		ST_SQ2,
		ST_SQS,
		ST_SQW,
		ST_DONE
	} st_t;

	// 5x5 Gaussian weight at window row i, column j
	function automatic logic [3:0] gauss_weight(input logic [2:0] i, input logic [2:0] j);
		logic [2:0] ri;
		logic [2:0] cj;
		logic [3:0] w;
		ri = (i > 3'd2) ? 3'd4 - i : i;
		cj = (j > 3'd2) ? 3'd4 - j : j;
		w  = 4'd0;
		unique case ({ri[1:0], cj[1:0]})
			4'b0000: w = 4'd2;
			4'b0001: w = 4'd4;
			4'b0010: w = 4'd5;
			4'b0100: w = 4'd4;
			4'b0101: w = 4'd9;
			4'b0110: w = 4'd12;
			4'b1000: w = 4'd5;
			4'b1001: w = 4'd12;
			4'b1010: w = 4'd15;
			default: w = 4'd0;
		endcase
		return w;
	endfunction

endpackage

### hdl/gbse_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbse_if
// Valid/ready channels for pixels in, results out and register writes.
// ----------------------------------------------------------------------------
interface gbse_pix_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] pixel_value;
	modport source(output valid, output action, output pixel_value, input ready);
	modport sink(input valid, input action, input pixel_value, output ready);
endinterface

interface gbse_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] blur_pixel;
	logic [7:0] edge_pixel;
	logic       last_pixel;
	modport source(output valid, output blur_pixel, output edge_pixel, output last_pixel,
		input ready);
	modport sink(input valid, input blur_pixel, input edge_pixel, input last_pixel,
		output ready);
endinterface

interface gbse_cfg_if;
	logic        valid;
	logic        ready;
	logic        index;
	logic [12:0] data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

### hdl/gaussian_blur_sobel_edge.sv
`timescale 1ns / 1ps
// An item that blurs a pixel reads its 5x5 window one pixel at a time, and one
// that gives a result reads its 3x3 window likewise and then waits for the
// bitwise square root; the one read port of each line store sets this pace.
// One item is in work at a time; a finished result waits in the output register
// while the next item is taken. Reset restores 640x480 and restarts the frame;
// line stores are not cleared.
// ----------------------------------------------------------------------------
// gaussian_blur_sobel_edge
// Streaming 5x5 Gaussian blur followed by a 3x3 Sobel edge magnitude.
// ----------------------------------------------------------------------------
module gaussian_blur_sobel_edge
	import gbse_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
)(
	input logic        clk,
	input logic        arst_n,
	gbse_pix_if.sink   pixels,
	gbse_res_if.source results,
	gbse_cfg_if.sink   cfg
);

	localparam int CW      = $clog2(MAX_WIDTH);
	localparam int WW      = $clog2(MAX_WIDTH + 1);
	localparam int TMPW    = (WW > WREG_W) ? WW : WREG_W;
	localparam int TW      = WW + HREG_W;
	localparam int SW      = TW + 1;
	localparam int IN_DEP  = IN_ROWS << CW;
	localparam int BL_DEP  = BLUR_ROWS << CW;

	// Registers and dimensions
	logic [WREG_W-1:0] width_q;
	logic [HREG_W-1:0] height_q;
	logic [TMPW-1:0]   wtmp;
	logic [WW-1:0]     w_c;
	logic [WW-1:0]     w_m1;
	logic [HREG_W-1:0] h_c;
	logic [HREG_W-1:0] h_m1;
	logic [TW-1:0]     total_q;
	logic [SW-1:0]     lag_b;
	logic [SW-1:0]     lag_e;

	// Stream position and trackers
	logic [SW-1:0]     s_q;
	logic [CW-1:0]     ic_q;
	logic [2:0]        islot_q;
	logic [HREG_W-1:0] br_q;
	logic [CW-1:0]     bc_q;
	logic [2:0]        bslot_q;
	logic [1:0]        b4_q;
	logic [HREG_W-1:0] orow_q;
	logic [CW-1:0]     ocol_q;
	logic [1:0]        o4_q;

	// Sequencer
	st_t        state_q;
	st_t        state_d;
	logic [2:0] i_q;
	logic [2:0] j_q;
	logic       act_q;
	logic [7:0] pix_q;
	logic       in_act_c, b_act_c, o_act_c;
	logic       in_act_q, b_act_q, o_act_q;
	logic       in_we, blur_we, sq_start, out_load, adv, last_c, stall;

	// Datapath
	logic [7:0]          mem_in [0:IN_DEP-1];
	logic [7:0]          mem_bl [0:BL_DEP-1];
	logic [7:0]          in_rd_q;
	logic [7:0]          bl_rd_q;
	logic                acc_en_s1, vld_s1, sob_en_s1;
	logic [3:0]          wgt_s1;
	logic [1:0]          si_s1, sj_s1;
	logic [15:0]         acc_q;
	logic [30:0]         prod_q;
	logic [8:0]          q0;
	logic [16:0]         rem_c;
	logic [7:0]          blur_val_q;
	logic signed [11:0]  gx_q, gy_q;
	logic [7:0]          center_q;
	logic [SQ_W-1:0]     sq_q;
	logic [SQ_W-1:0]     x_q;
	logic                sq_done;
	logic [10:0]         root;
	logic [7:0]          edge_c;
	logic                interior;
	logic                out_valid_q;
	logic [7:0]          out_blur_q, out_edge_q;
	logic                out_last_q;

	// Read address generation
	logic signed [HREG_W+1:0] rr;
	logic signed [WW+1:0]     cc;
	logic                     rvalid;
	logic [3:0]               slot_t;
	logic [2:0]               in_rslot;
	logic [CW+2:0]            in_raddr;
	logic [1:0]               bl_rslot;
	logic [WW+1:0]            bl_col;
	logic [CW+1:0]            bl_raddr;
	logic signed [11:0]       p_ext;

	// Clamp dimensions
	always_comb begin
		wtmp = TMPW'(width_q);
		if (wtmp < TMPW'(3)) begin
			wtmp = TMPW'(3);
		end else if (wtmp > TMPW'(MAX_WIDTH)) begin
			wtmp = TMPW'(MAX_WIDTH);
		end
		w_c = wtmp[WW-1:0];
		if (height_q < HREG_W'(3)) begin
			h_c = HREG_W'(3);
		end else if (height_q > HREG_W'(MAX_HEIGHT)) begin
			h_c = HREG_W'(MAX_HEIGHT);
		end else begin
			h_c = height_q;
		end
	end

	assign w_m1  = w_c - WW'(1);
	assign h_m1  = h_c - HREG_W'(1);
	assign lag_b = (SW'(w_c) << 1) + SW'(2);
	assign lag_e = (SW'(w_c) << 1) + SW'(w_c) + SW'(3);

	// Frame size product
	always_ff @(posedge clk) begin
		total_q <= TW'(w_c) * TW'(h_c);
	end

	// Phase activity of the current item
	assign in_act_c = s_q < SW'(total_q);
	assign b_act_c  = (s_q >= lag_b) && ((s_q - lag_b) < SW'(total_q));
	assign o_act_c  = (s_q >= lag_e) && ((s_q - lag_e) < SW'(total_q));
	assign last_c   = (orow_q == h_m1) && (WW'(ocol_q) == w_m1);
	assign stall    = o_act_q && out_valid_q && !results.ready;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (pixels.valid) state_d = ST_CHK;
			ST_CHK: begin
				if (b_act_c) state_d = ST_BRD;
				else if (o_act_c) state_d = ST_SRD;
				else state_d = ST_DONE;
			end
			ST_BRD:   if (i_q == 3'd4 && j_q == 3'd4) state_d = ST_BLAST;
			ST_BLAST: state_d = ST_DIV1;
			ST_DIV1:  state_d = ST_DIV2;
			ST_DIV2:  state_d = ST_BWR;
			ST_BWR:   state_d = o_act_q ? ST_SRD : ST_DONE;
			ST_SRD:   if (i_q == 3'd2 && j_q == 3'd2) state_d = ST_SLAST;
			ST_SLAST: state_d = ST_SQ1;
			ST_SQ1:   state_d = ST_SQ2;
			ST_SQ2:   state_d = ST_SQS;
			ST_SQS:   state_d = ST_SQW;
			ST_SQW:   if (sq_done) state_d = ST_DONE;
			ST_DONE:  if (!stall) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		pixels.ready = (state_q == ST_IDLE);
		in_we        = (state_q == ST_CHK) && in_act_c;
		blur_we      = (state_q == ST_BWR);
		sq_start     = (state_q == ST_SQS);
		adv          = (state_q == ST_DONE) && !stall;
		out_load     = adv && o_act_q;
	end

	assign cfg.ready = 1'b1;

	// Hold state, registers and trackers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			width_q  <= WREG_W'(640);
			height_q <= HREG_W'(480);
			s_q      <= '0;
			ic_q     <= '0;
			islot_q  <= '0;
			br_q     <= '0;
			bc_q     <= '0;
			bslot_q  <= '0;
			b4_q     <= '0;
			orow_q   <= '0;
			ocol_q   <= '0;
			o4_q     <= '0;
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				if (cfg.index == CFG_WIDTH) width_q <= cfg.data[WREG_W-1:0];
				else height_q <= cfg.data;
			end
			if (cfg.valid || (adv && o_act_q && last_c)) begin
				s_q     <= '0;
				ic_q    <= '0;
				islot_q <= '0;
				br_q    <= '0;
				bc_q    <= '0;
				bslot_q <= '0;
				b4_q    <= '0;
				orow_q  <= '0;
				ocol_q  <= '0;
				o4_q    <= '0;
			end else if (adv) begin
				s_q <= s_q + SW'(1);
				if (in_act_q) begin
					if (WW'(ic_q) == w_m1) begin
						ic_q    <= '0;
						islot_q <= (islot_q == 3'd5) ? 3'd0 : islot_q + 3'd1;
					end else begin
						ic_q <= ic_q + CW'(1);
					end
				end
				if (b_act_q) begin
					if (WW'(bc_q) == w_m1) begin
						bc_q    <= '0;
						br_q    <= br_q + HREG_W'(1);
						bslot_q <= (bslot_q == 3'd5) ? 3'd0 : bslot_q + 3'd1;
						b4_q    <= b4_q + 2'd1;
					end else begin
						bc_q <= bc_q + CW'(1);
					end
				end
				if (o_act_q) begin
					if (WW'(ocol_q) == w_m1) begin
						ocol_q <= '0;
						orow_q <= orow_q + HREG_W'(1);
						o4_q   <= o4_q + 2'd1;
					end else begin
						ocol_q <= ocol_q + CW'(1);
					end
				end
			end
		end
	end

	// Window counters and item capture
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && pixels.valid) begin
			act_q <= pixels.action;
			pix_q <= pixels.pixel_value;
		end
		if (state_q == ST_CHK) begin
			in_act_q <= in_act_c;
			b_act_q  <= b_act_c;
			o_act_q  <= o_act_c;
		end
		if (state_q == ST_CHK || state_q == ST_BWR) begin
			i_q <= '0;
			j_q <= '0;
		end else if (state_q == ST_BRD) begin
			if (j_q == 3'd4) begin
				j_q <= '0;
				i_q <= i_q + 3'd1;
			end else begin
				j_q <= j_q + 3'd1;
			end
		end else if (state_q == ST_SRD) begin
			if (j_q == 3'd2) begin
				j_q <= '0;
				i_q <= i_q + 3'd1;
			end else begin
				j_q <= j_q + 3'd1;
			end
		end
	end

	// Blur window address and border check
	always_comb begin
		rr     = $signed({2'b00, br_q}) + $signed({{(HREG_W-1){1'b0}}, i_q})
			- $signed((HREG_W+2)'(2));
		cc     = $signed({2'b00, WW'(bc_q)}) + $signed({{(WW-1){1'b0}}, j_q})
			- $signed((WW+2)'(2));
		rvalid = (rr >= 0) && (rr < $signed({2'b00, h_c}))
			&& (cc >= 0) && (cc < $signed({2'b00, w_c}));
		slot_t = 4'(bslot_q) + 4'(i_q) + 4'd4;
		if (slot_t >= 4'd12) slot_t = slot_t - 4'd12;
		else if (slot_t >= 4'd6) slot_t = slot_t - 4'd6;
		in_rslot = slot_t[2:0];
		in_raddr = {in_rslot, cc[CW-1:0]};
	end

	// Sobel window address; border reads are masked later
	always_comb begin
		bl_rslot = o4_q + 2'd3 + i_q[1:0];
		bl_col   = (WW+2)'(ocol_q) + (WW+2)'(j_q) - (WW+2)'(1);
		bl_raddr = {bl_rslot, bl_col[CW-1:0]};
	end

	// Input line store
	always_ff @(posedge clk) begin
		if (in_we) mem_in[{islot_q, ic_q}] <= act_q ? 8'd0 : pix_q;
		in_rd_q <= mem_in[in_raddr];
	end

	// Blur line store
	always_ff @(posedge clk) begin
		if (blur_we) mem_bl[{b4_q, bc_q}] <= blur_val_q;
		bl_rd_q <= mem_bl[bl_raddr];
	end

	// Read pipeline controls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_en_s1 <= 1'b0;
			sob_en_s1 <= 1'b0;
		end else begin
			acc_en_s1 <= (state_q == ST_BRD);
			sob_en_s1 <= (state_q == ST_SRD);
		end
	end

	assign p_ext = $signed({4'b0000, bl_rd_q});

	// Accumulate, divide and Sobel sums
	always_ff @(posedge clk) begin
		vld_s1 <= rvalid;
		wgt_s1 <= gauss_weight(i_q, j_q);
		si_s1  <= i_q[1:0];
		sj_s1  <= j_q[1:0];
		if (state_q == ST_CHK) begin
			acc_q <= '0;
		end else if (acc_en_s1 && vld_s1) begin
			acc_q <= acc_q + 16'(wgt_s1) * 16'(in_rd_q);
		end
		if (state_q == ST_DIV1) prod_q <= 31'(acc_q) * 31'(DIV_RECIP);
		if (state_q == ST_DIV2) blur_val_q <= (rem_c >= 17'(DIV_BY)) ? 8'(q0 + 9'd1) : q0[7:0];
		if (state_q == ST_CHK || state_q == ST_BWR) begin
			gx_q <= '0;
			gy_q <= '0;
		end else if (sob_en_s1) begin
			if (sj_s1 == 2'd0) gx_q <= gx_q - ((si_s1 == 2'd1) ? (p_ext <<< 1) : p_ext);
			else if (sj_s1 == 2'd2) gx_q <= gx_q + ((si_s1 == 2'd1) ? (p_ext <<< 1) : p_ext);
			if (si_s1 == 2'd0) gy_q <= gy_q - ((sj_s1 == 2'd1) ? (p_ext <<< 1) : p_ext);
			else if (si_s1 == 2'd2) gy_q <= gy_q + ((sj_s1 == 2'd1) ? (p_ext <<< 1) : p_ext);
			if (si_s1 == 2'd1 && sj_s1 == 2'd1) center_q <= bl_rd_q;
		end
		if (state_q == ST_SQ1) sq_q <= SQ_W'(gx_q * gx_q);
		if (state_q == ST_SQ2) x_q <= sq_q + SQ_W'(gy_q * gy_q);
	end

	// Reciprocal quotient and remainder for the correction step
	assign q0    = prod_q[DIV_SHIFT+8:DIV_SHIFT];
	assign rem_c = 17'(acc_q) - 17'(q0) * 17'(DIV_BY);

	gbse_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.x      (x_q),
		.done   (sq_done),
		.root   (root)
	);

	// Saturate the magnitude, zero on the border
	assign interior = (orow_q != '0) && (orow_q < h_m1)
		&& (ocol_q != '0) && (WW'(ocol_q) < w_m1);
	assign edge_c = !interior ? 8'd0 : (root > 11'd255) ? 8'd255 : root[7:0];

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_blur_q <= center_q;
			out_edge_q <= edge_c;
			out_last_q <= last_c;
		end
	end

	assign results.valid      = out_valid_q;
	assign results.blur_pixel = out_blur_q;
	assign results.edge_pixel = out_edge_q;
	assign results.last_pixel = out_last_q;

endmodule

### hdl/gbse_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbse_isqrt
// Iterative floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module gbse_isqrt
	import gbse_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [SQ_W-1:0] x,
	output logic            done,
	output logic [10:0]     root
);

	logic            busy_q;
	logic            done_q;
	logic [SQ_W-1:0] rem_q;
	logic [SQ_W-1:0] res_q;
	logic [SQ_W-1:0] bit_q;
	logic [SQ_W-1:0] trial;

	assign trial = res_q + bit_q;

	// Track busy and raise done after the last bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q == SQ_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Resolve one root bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= x;
			res_q <= '0;
			bit_q <= SQ_W'(1) << 20;
		end else if (busy_q) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[10:0];

endmodule
